/* rtl/core/eas_pkg.sv */
// Shared types and constants for the address syntax checker.
// Holds byte codes, length limits, counter widths and the class record.
// Depends on nothing; every other file imports it.
package eas_pkg;

  // Length limits
  localparam int MAX_ADDRESS_LENGTH = 254;
  localparam int MAX_LOCAL_LENGTH   = 64;
  localparam int MAX_LABEL_LENGTH   = 63;

  // Counter widths: each counter saturates one above its limit
  localparam int TOTAL_W = $clog2(MAX_ADDRESS_LENGTH + 2);
  localparam int LOCAL_W = $clog2(MAX_LOCAL_LENGTH + 2);
  localparam int LABEL_W = $clog2(MAX_LABEL_LENGTH + 2);

  // Byte codes
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DEL    = 8'h7F;

  // Queue between classifier and checker
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified byte as passed through the queue
  typedef struct packed {
    logic is_at;
    logic is_dot;
    logic is_hyphen;
    logic is_label;
    logic is_bad_local;
    logic last;
  } eas_class_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } eas_qstat_t;

endpackage

/* rtl/core/eas_classify.sv */
// Front end: sorts each incoming byte into the character classes the checker uses.
// Purely combinational; depends on eas_pkg.
module eas_classify (
  input  logic [7:0]          character,
  input  logic                last,
  output eas_pkg::eas_class_t cls
);
  import eas_pkg::*;

  // Decode the byte into class flags
  always_comb begin
    cls.is_at        = (character == CHAR_AT);
    cls.is_dot       = (character == CHAR_DOT);
    cls.is_hyphen    = (character == CHAR_HYPHEN);
    cls.is_label     = (character inside {["A":"Z"], ["a":"z"], ["0":"9"]}) ||
                       (character == CHAR_HYPHEN);
    cls.is_bad_local = (character <= CHAR_SPACE) || (character == CHAR_DEL);
    cls.last         = last;
  end

endmodule

/* rtl/core/eas_queue.sv */
// Short queue of classified bytes between front end and checker.
// Register storage with read and write pointers; depends on eas_pkg.
module eas_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  eas_pkg::eas_class_t push_item,
  input  logic                pop,
  output eas_pkg::eas_class_t head,
  output eas_pkg::eas_qstat_t stat
);
  import eas_pkg::*;

  eas_class_t        store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = store[rd_ptr];

  // Write the storage; no reset needed on payload
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/eas_check.sv */
// Back end: applies the syntax rules byte by byte and holds the verdict register.
// Depends on eas_pkg for limits, widths and the class record.
module eas_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  eas_pkg::eas_class_t item,
  output logic                item_take,
  output logic                verdict_valid,
  output logic                verdict,
  input  logic                verdict_ready
);
  import eas_pkg::*;

  logic               seen_at,        seen_at_next;
  logic               failed,         failed_next;
  logic [TOTAL_W-1:0] total_count,    total_count_next;
  logic [LOCAL_W-1:0] local_count,    local_count_next;
  logic [LABEL_W-1:0] label_length,   label_length_next;
  logic               prev_dot,       prev_dot_next;
  logic               prev_hyphen,    prev_hyphen_next;
  logic [1:0]         labels_closed,  labels_closed_next;
  logic               label_ok;
  logic               final_label_ok;
  logic               result;

  // Take a byte unless it carries a verdict that cannot be stored
  assign item_take = item_valid && (!item.last || !verdict_valid || verdict_ready);

  // Current label closes cleanly
  assign label_ok = (label_length != '0) &&
                    (label_length <= LABEL_W'(MAX_LABEL_LENGTH)) && !prev_hyphen;

  // Per-byte rule update
  always_comb begin
    seen_at_next       = seen_at;
    failed_next        = failed;
    local_count_next   = local_count;
    label_length_next  = label_length;
    prev_dot_next      = prev_dot;
    prev_hyphen_next   = prev_hyphen;
    labels_closed_next = labels_closed;
    total_count_next   = (total_count <= TOTAL_W'(MAX_ADDRESS_LENGTH)) ?
                         total_count + TOTAL_W'(1) : total_count;

    if (!seen_at) begin
      if (item.is_at) begin
        if ((local_count == '0) || prev_dot) failed_next = 1'b1;
        seen_at_next      = 1'b1;
        prev_dot_next     = 1'b0;
        prev_hyphen_next  = 1'b0;
        label_length_next = '0;
      end else begin
        if (item.is_bad_local) failed_next = 1'b1;
        if (item.is_dot && ((local_count == '0) || prev_dot)) failed_next = 1'b1;
        prev_dot_next = item.is_dot;
        if (local_count <= LOCAL_W'(MAX_LOCAL_LENGTH)) begin
          local_count_next = local_count + LOCAL_W'(1);
        end
      end
    end else begin
      if (item.is_dot) begin
        if (!label_ok) begin
          failed_next = 1'b1;
        end else if (labels_closed < 2'd2) begin
          labels_closed_next = labels_closed + 2'd1;
        end
        label_length_next = '0;
        prev_hyphen_next  = 1'b0;
      end else if (item.is_label) begin
        if ((label_length == '0) && item.is_hyphen) failed_next = 1'b1;
        if (label_length <= LABEL_W'(MAX_LABEL_LENGTH)) begin
          label_length_next = label_length + LABEL_W'(1);
        end
        prev_hyphen_next = item.is_hyphen;
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // Verdict on the final byte: closing the last label must give two labels
  assign final_label_ok = (label_length_next != '0) &&
                          (label_length_next <= LABEL_W'(MAX_LABEL_LENGTH)) &&
                          !prev_hyphen_next;
  assign result = !failed_next && seen_at_next &&
                  (total_count_next <= TOTAL_W'(MAX_ADDRESS_LENGTH)) &&
                  (local_count_next != '0) &&
                  (local_count_next <= LOCAL_W'(MAX_LOCAL_LENGTH)) &&
                  final_label_ok && (labels_closed_next != 2'd0);

  // Hold rule state; clear after each address
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_at       <= 1'b0;
      failed        <= 1'b0;
      total_count   <= '0;
      local_count   <= '0;
      label_length  <= '0;
      prev_dot      <= 1'b0;
      prev_hyphen   <= 1'b0;
      labels_closed <= '0;
    end else if (item_take) begin
      if (item.last) begin
        seen_at       <= 1'b0;
        failed        <= 1'b0;
        total_count   <= '0;
        local_count   <= '0;
        label_length  <= '0;
        prev_dot      <= 1'b0;
        prev_hyphen   <= 1'b0;
        labels_closed <= '0;
      end else begin
        seen_at       <= seen_at_next;
        failed        <= failed_next;
        total_count   <= total_count_next;
        local_count   <= local_count_next;
        label_length  <= label_length_next;
        prev_dot      <= prev_dot_next;
        prev_hyphen   <= prev_hyphen_next;
        labels_closed <= labels_closed_next;
      end
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (item_take && item.last) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      verdict <= result;
    end
  end

endmodule

/* rtl/core/email_address_syntax_checker_unit.sv */
// Address syntax checker: one byte per request in, one verdict per address out.
// Throughput: one byte per cycle sustained while a final byte is not held back by a pending verdict.
// Verdict path: the final byte is first stored in the queue; when the checker takes it,
// the checker loads the verdict register and raises m_tvalid.
// Reset: synchronous rst empties the queue, clears rule state and drops m_tvalid.
module email_address_syntax_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);
  import eas_pkg::*;

  eas_class_t front_cls;
  eas_class_t q_head;
  eas_qstat_t q_stat;
  logic       push;
  logic       pop;
  logic       verdict;

  // Accept bytes while the queue has room
  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  eas_classify u_classify (
    .character (s_tdata),
    .last      (s_tlast),
    .cls       (front_cls)
  );

  eas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_cls),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  eas_check u_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (!q_stat.empty),
    .item          (q_head),
    .item_take     (pop),
    .verdict_valid (m_tvalid),
    .verdict       (verdict),
    .verdict_ready (m_tready)
  );

  assign m_tdata = {7'b0, verdict};

  // Queue status is never both full and empty
  assert property (@(posedge clk) disable iff (rst) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Nothing is taken from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  // A new verdict only follows a final byte taken by the checker
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(pop && q_head.last))
    else $error("verdict without a final byte");

  // Reset leaves no verdict pending
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("verdict valid after reset");

endmodule
